// ===== design/spq_pkg.sv =====
// spq_pkg: shared types and codes for the sorted-insert priority queue
// holds entry, channel payload and cell control types; no dependencies
package spq_pkg;

  localparam int KEY_W = 16;
  localparam int COORD_W = 8;
  localparam int OCC_W = 7;
  localparam int STATUS_W = 2;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_REMOVE = 1'b1
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // stored entry, priority is the sort key
  typedef struct packed {
    logic [KEY_W-1:0]   priority_key;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } entry_t;

  typedef struct packed {
    action_t            action;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [KEY_W-1:0]   priority_req;
  } req_t;

  typedef struct packed {
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_col;
    logic [KEY_W-1:0]   out_priority;
    logic [OCC_W-1:0]   occupancy;
    status_t            status;
  } rsp_t;

  // control broadcast to every cell
  typedef struct packed {
    logic   ins;      // accepted insert that fits
    logic   rem;      // accepted remove from a non-empty queue
    entry_t new_entry;
  } cell_cmd_t;

endpackage

// ===== design/spq_stream_if.sv =====
// spq_stream_if: valid/ready channel carrying one item of a given payload type
// depends on nothing; payload type chosen at instantiation
interface spq_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
  modport mon    (input valid, input data, input ready);
endinterface

// ===== design/spq_cell.sv =====
// spq_cell: one slot of the sorted chain, holds an entry and shifts with its neighbors
// depends on spq_pkg
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_cmd_t cmd,
  input  logic               occupied,   // slot holds a live entry
  input  logic               prev_ahead, // new entry lands at or ahead of the previous slot
  input  spq_pkg::entry_t    prev_entry,
  input  spq_pkg::entry_t    next_entry,
  output logic               ahead,      // new entry lands at or ahead of this slot
  output spq_pkg::entry_t    entry
);
  import spq_pkg::*;

  // new entry goes ahead of an equal or larger key, or into the first free slot
  assign ahead = !occupied || (cmd.new_entry.priority_key <= entry.priority_key);

  // shift right behind the insert point, take the new entry at it, shift left on remove
  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (prev_ahead) begin
        entry <= prev_entry;
      end else if (ahead) begin
        entry <= cmd.new_entry;
      end
    end else if (cmd.rem) begin
      entry <= next_entry;
    end
  end

endmodule

// ===== design/sorted_insert_priority_queue.sv =====
// sorted_insert_priority_queue: bounded min-priority queue built as a row of sorting cells
// depends on spq_pkg, spq_stream_if and spq_cell
//
// usage
//   in_ch carries one request item: action (insert or remove), row, col, priority_req.
//   out_ch returns exactly one result item per request: removed entry (zero for
//   inserts and failed removes), occupancy after the item and a status code.
//   entries leave in ascending priority; equal priorities leave newest first.
//   each cell compares the incoming key with its own entry in parallel, so an
//   insert or remove updates the whole chain at once.
//   the result is registered and appears in the cycle after acceptance.
//   throughput: one item per cycle while results are taken, set by the single output
//   register; the queue takes a new item in the same cycle the waiting result is taken.
//   stall: while a result sits unaccepted on out_ch, in_ch.ready stays low and
//   the queue holds its contents.
//   reset: the count clears to zero and the output register empties; the entry
//   slots keep whatever they hold and are never read until written.
//   a remove from an empty queue reports status empty; an insert into a full
//   queue is refused with status full; neither changes the queue.
module sorted_insert_priority_queue #(
  parameter int CAPACITY = 64
) (
  input  logic              clk,
  input  logic              rst,
  spq_stream_if.sink        in_ch,
  spq_stream_if.source      out_ch
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             accept;
  logic             is_full;
  logic             is_empty;
  req_t             req;
  cell_cmd_t        cmd;
  rsp_t             rsp_next;
  rsp_t             rsp;
  logic             rsp_valid;

  entry_t entries [CAPACITY];
  logic   ahead   [CAPACITY];

  assign req      = in_ch.data;
  assign accept   = in_ch.valid && in_ch.ready;
  assign is_full  = (count == CNT_W'(CAPACITY));
  assign is_empty = (count == '0);

  // input stalls only while a result waits
  assign in_ch.ready = !rsp_valid || out_ch.ready;

  // command broadcast to the chain
  always_comb begin
    cmd.ins                    = accept && (req.action == ACT_INSERT) && !is_full;
    cmd.rem                    = accept && (req.action == ACT_REMOVE) && !is_empty;
    cmd.new_entry.priority_key = req.priority_req;
    cmd.new_entry.row          = req.row;
    cmd.new_entry.col          = req.col;
  end

  // chain of cells, head at slot zero
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic   prev_ahead;
    entry_t prev_entry;
    entry_t next_entry;
    if (i == 0) begin : g_head
      assign prev_ahead = 1'b0;
      assign prev_entry = entries[0];
    end else begin : g_mid
      assign prev_ahead = ahead[i-1];
      assign prev_entry = entries[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign next_entry = entries[i];
    end else begin : g_body
      assign next_entry = entries[i+1];
    end
    spq_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .occupied   (count > CNT_W'(i)),
      .prev_ahead (prev_ahead),
      .prev_entry (prev_entry),
      .next_entry (next_entry),
      .ahead      (ahead[i]),
      .entry      (entries[i])
    );
  end

  // count and result for the accepted item
  always_comb begin
    count_next = count;
    rsp_next   = '0;
    rsp_next.status = ST_OK;
    if (cmd.ins) begin
      count_next = count + 1'b1;
    end else if (cmd.rem) begin
      count_next            = count - 1'b1;
      rsp_next.out_row      = entries[0].row;
      rsp_next.out_col      = entries[0].col;
      rsp_next.out_priority = entries[0].priority_key;
    end else if (req.action == ACT_REMOVE) begin
      rsp_next.status = ST_EMPTY;
    end else begin
      rsp_next.status = ST_FULL;
    end
    rsp_next.occupancy = OCC_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (out_ch.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // result payload register
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  assign out_ch.valid = rsp_valid;
  assign out_ch.data  = rsp;

endmodule

// ===== design/spq_checker.sv =====
// spq_checker: port-level checks on the sorted-insert priority queue, bound to the top level
// depends on spq_pkg
module spq_checker #(
  parameter int CAPACITY = 64
) (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input spq_pkg::rsp_t out_data
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // a failed remove carries no entry and an empty queue
  a_empty_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_EMPTY |->
      out_data.out_row == '0 && out_data.out_col == '0 &&
      out_data.out_priority == '0 && out_data.occupancy == '0)
    else $error("empty status with nonzero entry or occupancy");

  // a refused insert reports a full queue
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_FULL |->
      out_data.occupancy == OCC_W'(CNT_W'(CAPACITY)))
    else $error("full status without full occupancy");

  // every accepted item gives a result on the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item without result");

  // a waiting result holds its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind sorted_insert_priority_queue spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
